/* hdl/assert_macros.svh */
// ------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, skipped while reset is high.
`define HWG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("hwg: assertion failed");

// Next-cycle implication, checked during reset as well.
`define HWG_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hwg: assertion failed");

`endif

/* hdl/hwg_pkg.sv */
// ------------------------------------------------------------------------
// hwg_pkg
// Types, hash primes and sizing helpers for the hashed weight generator.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package hwg_pkg;

  typedef enum logic [1:0] {
    MODE_CONV = 2'd0,
    MODE_DW   = 2'd1,
    MODE_LIN  = 2'd2,
    MODE_WR   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_LAYER     = 2'd0,
    REG_BOOK_SIZE = 2'd1,
    REG_SIGN_EN   = 2'd2
  } reg_idx_t;

  localparam int LAYER_W   = 8;
  localparam int VALUE_W   = 8;
  localparam int WEIGHT_W  = 9;
  localparam int CFG_IDX_W = 2;
  localparam int MOD_STEP  = 5;
  localparam int W_MAX     = 127;
  localparam int W_MIN     = -128;

  // bucket hash primes
  localparam logic [31:0] P_A     = 32'd1337;
  localparam logic [31:0] P_B     = 32'd7919;
  localparam logic [31:0] P_C     = 32'd2971;
  localparam logic [31:0] P_D     = 32'd6151;
  localparam logic [31:0] P_LAYER = 32'd104729;

  // sign hash primes
  localparam logic [31:0] S_A      = 32'd4099;
  localparam logic [31:0] S_B      = 32'd6151;
  localparam logic [31:0] S_C      = 32'd14887;
  localparam logic [31:0] S_CONV_C = S_A + S_B;
  localparam logic [31:0] S_CONV_L = S_C + 32'd11;
  localparam logic [31:0] S_DW_L   = S_A + 32'd29;

  typedef struct packed {
    logic               valid;
    mode_t              mode;
    logic               neg;
    logic [VALUE_W-1:0] value;
  } hwg_ctl_t;

  function automatic int hash_width(int max_ch, int max_k);
    longint mx;
    mx = longint'(max_ch - 1) * longint'(P_A + P_B)
       + longint'(max_k - 1) * longint'(P_B + P_C + P_D)
       + longint'((2 ** LAYER_W) - 1) * longint'(P_LAYER);
    return $clog2(mx + 1);
  endfunction

  function automatic int mod_stages(int hw);
    return (hw + MOD_STEP - 1) / MOD_STEP;
  endfunction

  // edges from the accepting edge to the edge that takes the result
  function automatic int accept_to_done(int max_ch, int max_k);
    return 4 + mod_stages(hash_width(max_ch, max_k));
  endfunction

endpackage

/* hdl/hwg_ram.sv */
// ------------------------------------------------------------------------
// hwg_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/hwg_hash.sv */
// ------------------------------------------------------------------------
// hwg_hash
// Two-stage hash front end: prime products and sign, then the bucket sum.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwg_hash import hwg_pkg::*; #(
  parameter int CH_W = 6,
  parameter int K_W  = 3,
  parameter int AW   = 8,
  parameter int HS_W = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  mode_t              mode,
  input  logic [CH_W-1:0]    out_index,
  input  logic [CH_W-1:0]    in_index,
  input  logic [K_W-1:0]     kern_row,
  input  logic [K_W-1:0]     kern_col,
  input  logic [AW-1:0]      entry_addr,
  input  logic [VALUE_W-1:0] entry_value,
  input  logic [LAYER_W-1:0] layer,
  input  logic               sign_en,
  output hwg_ctl_t           ctl,
  output logic [HS_W-1:0]    hsum,
  output logic [AW-1:0]      addr
);

  logic [HS_W-1:0] o_x, i_x, r_x, c_x, l_x;
  logic [HS_W-1:0] t0_next, t1_next, t2_next, t3_next, t4_next;
  logic [HS_W-1:0] t0, t1, t2, t3, t4;
  logic            par;
  hwg_ctl_t        ctl_next, ctl_a;
  logic [AW-1:0]   addr_a;

  assign o_x = HS_W'(out_index);
  assign i_x = HS_W'(in_index);
  assign r_x = HS_W'(kern_row);
  assign c_x = HS_W'(kern_col);
  assign l_x = HS_W'(layer);

  always_comb begin
    t0_next = HS_W'(o_x * HS_W'(P_A));
    t1_next = HS_W'(i_x * HS_W'(P_B));
    t2_next = '0;
    t3_next = '0;
    t4_next = HS_W'(l_x * HS_W'(P_LAYER));
    par     = 1'b0;
    case (mode)
      MODE_CONV: begin
        t2_next = HS_W'(r_x * HS_W'(P_C));
        t3_next = HS_W'(c_x * HS_W'(P_D));
        par = (out_index[0] & S_A[0]) ^ (in_index[0] & S_B[0])
            ^ (kern_row[0] & S_C[0]) ^ (kern_col[0] & S_CONV_C[0])
            ^ (layer[0] & S_CONV_L[0]);
      end
      MODE_DW: begin
        t1_next = HS_W'(r_x * HS_W'(P_B));
        t2_next = HS_W'(c_x * HS_W'(P_C));
        par = (out_index[0] & S_A[0]) ^ (kern_row[0] & S_B[0])
            ^ (kern_col[0] & S_C[0]) ^ (layer[0] & S_DW_L[0]);
      end
      MODE_LIN: begin
        t4_next = HS_W'(l_x * HS_W'(P_C));
        par = (out_index[0] & S_A[0]) ^ (in_index[0] & S_B[0])
            ^ (layer[0] & S_C[0]);
      end
      default: begin
        t0_next = '0;
        t1_next = '0;
        t4_next = '0;
      end
    endcase
    ctl_next.valid = take;
    ctl_next.mode  = mode;
    ctl_next.neg   = sign_en & ~par;  // even sign sum negates
    ctl_next.value = entry_value;
  end

  always_ff @(posedge clk) begin
    t0     <= t0_next;
    t1     <= t1_next;
    t2     <= t2_next;
    t3     <= t3_next;
    t4     <= t4_next;
    addr_a <= entry_addr;
    hsum   <= t0 + t1 + t2 + t3 + t4;
    addr   <= addr_a;
    if (rst) begin
      ctl_a.valid <= 1'b0;
      ctl.valid   <= 1'b0;
    end else begin
      ctl_a <= ctl_next;
      ctl   <= ctl_a;
    end
  end

endmodule

/* hdl/hwg_mod.sv */
// ------------------------------------------------------------------------
// hwg_mod
// Pipelined restoring remainder: hash sum modulo the codebook size,
// MOD_STEP quotient bits per stage.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwg_mod import hwg_pkg::*; #(
  parameter int AW   = 8,
  parameter int HS_W = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [AW:0]     modulus,
  input  hwg_ctl_t        ctl_in,
  input  logic [HS_W-1:0] hsum,
  input  logic [AW-1:0]   addr_in,
  output hwg_ctl_t        ctl_out,
  output logic [AW-1:0]   bucket,
  output logic [AW-1:0]   addr_out
);

  localparam int NSTG = mod_stages(HS_W);
  localparam int PAD  = NSTG * MOD_STEP;

  hwg_ctl_t      ctl_q  [NSTG];
  logic [AW-1:0] rem_q  [NSTG];
  logic [PAD-1:0] bits_q [NSTG];
  logic [AW-1:0] addr_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [AW-1:0]  rem_in;
    logic [PAD-1:0] bits_in;
    hwg_ctl_t       ctl_prev;
    logic [AW-1:0]  addr_prev;
    logic [AW-1:0]  rem_next;
    logic [AW:0]    trial;

    if (s == 0) begin : g_first
      assign rem_in    = '0;
      assign bits_in   = PAD'(hsum);
      assign ctl_prev  = ctl_in;
      assign addr_prev = addr_in;
    end else begin : g_rest
      assign rem_in    = rem_q[s-1];
      assign bits_in   = bits_q[s-1];
      assign ctl_prev  = ctl_q[s-1];
      assign addr_prev = addr_q[s-1];
    end

    always_comb begin
      rem_next = rem_in;
      trial    = '0;
      for (int k = 0; k < MOD_STEP; k++) begin
        trial = {rem_next, bits_in[PAD-1-k]};
        if (trial >= modulus) begin
          trial = trial - modulus;
        end
        rem_next = trial[AW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s]  <= rem_next;
      bits_q[s] <= bits_in << MOD_STEP;
      addr_q[s] <= addr_prev;
      if (rst) begin
        ctl_q[s].valid <= 1'b0;
      end else begin
        ctl_q[s] <= ctl_prev;
      end
    end
  end

  assign ctl_out  = ctl_q[NSTG-1];
  assign bucket   = rem_q[NSTG-1];
  assign addr_out = addr_q[NSTG-1];

endmodule

/* hdl/hashed_weight_generator.sv */
// ------------------------------------------------------------------------
// hashed_weight_generator
// Hashed weight sharing: weights generated from coordinates via a codebook.
// ------------------------------------------------------------------------
// Input: an item is taken on a rising edge with start high and busy low.
//   mode 0/1/2 asks for a conv, depthwise or linear weight at the given
//   coordinates; mode 3 writes entry_value into codebook entry entry_addr.
// Output: done is high for one cycle with weight and bucket; the receiver
//   must take it then. Write items give no result.
// Config: cfg_write/cfg_index/cfg_data write layer_number, book_size and
//   sign_enable; write them only while no item is in flight.
// Throughput: one item every cycle. busy is high only during reset.
// Pipeline: two hash stages, one remainder stage per five quotient bits,
//   then the codebook read and the sign/saturate stage.
// Codebook writes and reads share one pipeline slot, so they are applied
//   in item order and need no forwarding.
// Reset: clears the pipeline and the registers (book_size 1); the codebook
//   is not cleared and must be written before it is read.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_weight_generator import hwg_pkg::*; #(
  parameter int BOOK_DEPTH   = 256,
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_KERNEL   = 8,
  localparam int AW    = $clog2(BOOK_DEPTH),
  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int K_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
  localparam int CFG_W = (AW + 1 > LAYER_W) ? AW + 1 : LAYER_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 mode,
  input  logic [CH_W-1:0]            out_index,
  input  logic [CH_W-1:0]            in_index,
  input  logic [K_W-1:0]             kern_row,
  input  logic [K_W-1:0]             kern_col,
  input  logic [AW-1:0]              entry_addr,
  input  logic signed [VALUE_W-1:0]  entry_value,
  output logic                       done,
  output logic signed [WEIGHT_W-1:0] weight,
  output logic [AW-1:0]              bucket,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int HS_W = hash_width(MAX_CHANNELS, MAX_KERNEL);

  logic [LAYER_W-1:0] layer_number;
  logic [AW:0]        modulus;
  logic [AW:0]        size_in;
  logic               sign_enable;

  hwg_ctl_t        ctl_h, ctl_m, ctl_r;
  logic [HS_W-1:0] hsum;
  logic [AW-1:0]   addr_h, addr_m;
  logic [AW-1:0]   bucket_m, bucket_r;
  logic            ram_we;
  logic [VALUE_W-1:0] ram_rdata;
  logic signed [WEIGHT_W-1:0] w_raw, w_next;

  assign busy    = rst;
  assign size_in = cfg_data[AW:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_number <= '0;
      modulus      <= (AW+1)'(1);
      sign_enable  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LAYER: begin
          layer_number <= cfg_data[LAYER_W-1:0];
        end
        REG_BOOK_SIZE: begin
          if (size_in == '0) begin
            modulus <= (AW+1)'(1);
          end else if (size_in > (AW+1)'(BOOK_DEPTH)) begin
            modulus <= (AW+1)'(BOOK_DEPTH);
          end else begin
            modulus <= size_in;
          end
        end
        REG_SIGN_EN: begin
          sign_enable <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  hwg_hash #(
    .CH_W (CH_W),
    .K_W  (K_W),
    .AW   (AW),
    .HS_W (HS_W)
  ) u_hash (
    .clk         (clk),
    .rst         (rst),
    .take        (start & ~busy),
    .mode        (mode_t'(mode)),
    .out_index   (out_index),
    .in_index    (in_index),
    .kern_row    (kern_row),
    .kern_col    (kern_col),
    .entry_addr  (entry_addr),
    .entry_value (entry_value),
    .layer       (layer_number),
    .sign_en     (sign_enable),
    .ctl         (ctl_h),
    .hsum        (hsum),
    .addr        (addr_h)
  );

  hwg_mod #(
    .AW   (AW),
    .HS_W (HS_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .modulus  (modulus),
    .ctl_in   (ctl_h),
    .hsum     (hsum),
    .addr_in  (addr_h),
    .ctl_out  (ctl_m),
    .bucket   (bucket_m),
    .addr_out (addr_m)
  );

  assign ram_we = ctl_m.valid && (ctl_m.mode == MODE_WR)
               && ({1'b0, addr_m} < (AW+1)'(BOOK_DEPTH));

  hwg_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (BOOK_DEPTH)
  ) u_book (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_m),
    .wdata (ctl_m.value),
    .raddr (bucket_m),
    .rdata (ram_rdata)
  );

  always_comb begin
    w_raw  = {ram_rdata[VALUE_W-1], ram_rdata};
    w_next = ctl_r.neg ? -w_raw : w_raw;
    if (ctl_r.mode != MODE_LIN) begin
      if (w_next > W_MAX) begin
        w_next = WEIGHT_W'(W_MAX);
      end else if (w_next < W_MIN) begin
        w_next = WEIGHT_W'(W_MIN);
      end
    end
  end

  always_ff @(posedge clk) begin
    bucket_r <= bucket_m;
    weight   <= w_next;
    bucket   <= bucket_r;
    if (rst) begin
      ctl_r.valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      ctl_r <= ctl_m;
      done  <= ctl_r.valid && (ctl_r.mode != MODE_WR);
    end
  end

endmodule

/* hdl/hwg_checker.sv */
// ------------------------------------------------------------------------
// hwg_checker
// Port-level timing and range checks, bound to the top level.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hwg_checker import hwg_pkg::*; #(
  parameter int BOOK_DEPTH   = 256,
  parameter int MAX_CHANNELS = 64,
  parameter int MAX_KERNEL   = 8
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 mode,
  input logic                       done,
  input logic signed [WEIGHT_W-1:0] weight
);

  localparam int LAT = accept_to_done(MAX_CHANNELS, MAX_KERNEL);
  localparam int DEPTH_CHK = BOOK_DEPTH;

  logic take;
  assign take = start && !busy && (DEPTH_CHK > 0);

  `HWG_ASSERT_NEXT(a_reset_clears, clk, rst, !done)
  `HWG_ASSERT_IMP(a_read_gives_word, clk, rst, take && mode != MODE_WR, ##LAT done)
  `HWG_ASSERT_IMP(a_write_silent, clk, rst, take && mode == MODE_WR, ##LAT !done)
  `HWG_ASSERT_IMP(a_done_has_item, clk, rst, done, $past(take && mode != MODE_WR, LAT))
  `HWG_ASSERT_IMP(a_sat_range, clk, rst, done && ($past(mode, LAT) != MODE_LIN), weight <= 127)

endmodule

bind hashed_weight_generator hwg_checker #(
  .BOOK_DEPTH   (BOOK_DEPTH),
  .MAX_CHANNELS (MAX_CHANNELS),
  .MAX_KERNEL   (MAX_KERNEL)
) u_hwg_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .mode   (mode),
  .done   (done),
  .weight (weight)
);

/* test/hashed_weight_generator_tb.sv */
// ------------------------------------------------------------------------
// hashed_weight_generator_tb
// Drives conv, depthwise, linear and codebook-write words into the weight
// generator and checks every weight and bucket against a local hash model.
// A directed table comes first. It covers the extremes, sign flips,
// saturation, book size 0 and an unused register index. A full codebook
// fill and random phases over several register settings follow.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_weight_generator_tb import hwg_pkg::*;;

  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_WORDS  = 180;
  localparam int NUM_PHASES   = 8;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    mode_t             md;
    logic [5:0]        o;
    logic [5:0]        i;
    logic [2:0]        r;
    logic [2:0]        c;
    logic [7:0]        addr;
    logic signed [7:0] val;
  } word_t;

  typedef struct {
    logic signed [8:0] wt;
    logic [7:0]        bk;
  } weight_rec_t;

  typedef struct {
    bit          reg_wr;
    logic [1:0]  idx;
    logic [8:0]  data;
    word_t       w;
    bit          typed;
    weight_rec_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          mode = '0;
  logic [5:0]          out_index = '0;
  logic [5:0]          in_index = '0;
  logic [2:0]          kern_row = '0;
  logic [2:0]          kern_col = '0;
  logic [7:0]          entry_addr = '0;
  logic signed [7:0]   entry_value = '0;
  logic                done;
  logic signed [8:0]   weight;
  logic [7:0]          bucket;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [8:0]          cfg_data = '0;

  // local copy of block state
  logic signed [7:0]   book_mem [256];
  logic [7:0]          layer_cfg = 8'd0;
  logic [8:0]          bsize_cfg = 9'd1;
  logic                sign_cfg = 1'b0;

  weight_rec_t         weight_q[$];
  dir_row_t            dir_tab[$];
  int                  err_cnt = 0;
  int                  cycle_cnt = 0;

  int ph_layer [NUM_PHASES] = '{0, 255, 17, 128, 3, 200, 0, 255};
  int ph_size  [NUM_PHASES] = '{256, 256, 1, 511, 257, 0, 2, 255};
  int ph_sign  [NUM_PHASES] = '{0, 1, 1, 1, 0, 1, 0, 0};

  hashed_weight_generator uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .out_index   (out_index),
    .in_index    (in_index),
    .kern_row    (kern_row),
    .kern_col    (kern_col),
    .entry_addr  (entry_addr),
    .entry_value (entry_value),
    .done        (done),
    .weight      (weight),
    .bucket      (bucket),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic weight_rec_t hash_lookup(word_t w);
    longint      o, i, r, c, lyr, hs, ss;
    int          m, v;
    weight_rec_t res;
    o = longint'(w.o);
    i = longint'(w.i);
    r = longint'(w.r);
    c = longint'(w.c);
    lyr = longint'(layer_cfg);
    case (w.md)
      MODE_CONV: begin
        hs = o * 1337 + i * 7919 + r * 2971 + c * 6151 + lyr * 104729;
        ss = o * 4099 + i * 6151 + r * 14887 + c * (4099 + 6151) + lyr * (14887 + 11);
      end
      MODE_DW: begin
        hs = o * 1337 + r * 7919 + c * 2971 + lyr * 104729;
        ss = o * 4099 + r * 6151 + c * 14887 + lyr * (4099 + 29);
      end
      default: begin
        hs = o * 1337 + i * 7919 + lyr * 2971;
        ss = o * 4099 + i * 6151 + lyr * 14887;
      end
    endcase
    m = (bsize_cfg == 0) ? 1 : (bsize_cfg > 256) ? 256 : int'(bsize_cfg);
    res.bk = 8'(hs % m);
    v = int'(book_mem[res.bk]);
    // even sign sum negates
    if (sign_cfg && ss[0] == 1'b0) v = -v;
    if (w.md != MODE_LIN) begin
      if (v > 127) v = 127;
      if (v < -128) v = -128;
    end
    res.wt = 9'(v);
    return res;
  endfunction

  function automatic word_t mk_word(mode_t md, logic [5:0] o, logic [5:0] i, logic [2:0] r,
                                    logic [2:0] c, logic [7:0] addr, logic signed [7:0] val);
    word_t w;
    w.md = md;
    w.o = o;
    w.i = i;
    w.r = r;
    w.c = c;
    w.addr = addr;
    w.val = val;
    return w;
  endfunction

  function automatic word_t rand_word();
    mode_t md;
    md = ($urandom_range(0, 3) == 0) ? MODE_WR : mode_t'($urandom_range(0, 2));
    return mk_word(md, 6'($urandom), 6'($urandom), 3'($urandom), 3'($urandom),
                   8'($urandom), 8'($urandom));
  endfunction

  function automatic dir_row_t rd_row(mode_t md, logic [5:0] o, logic [5:0] i,
                                      logic [2:0] r, logic [2:0] c);
    dir_row_t d;
    d.reg_wr = 1'b0;
    d.idx = '0;
    d.data = '0;
    d.w = mk_word(md, o, i, r, c, 8'd0, 8'sd0);
    d.typed = 1'b0;
    d.res.wt = '0;
    d.res.bk = '0;
    return d;
  endfunction

  function automatic dir_row_t rd_chk(mode_t md, logic [5:0] o, logic [5:0] i, logic [2:0] r,
                                      logic [2:0] c, logic signed [8:0] wt, logic [7:0] bk);
    dir_row_t d;
    d = rd_row(md, o, i, r, c);
    d.typed = 1'b1;
    d.res.wt = wt;
    d.res.bk = bk;
    return d;
  endfunction

  function automatic dir_row_t wr_row(logic [7:0] addr, logic signed [7:0] val);
    dir_row_t d;
    d = rd_row(MODE_WR, 6'd0, 6'd0, 3'd0, 3'd0);
    d.w.addr = addr;
    d.w.val = val;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic [1:0] idx, logic [8:0] data);
    dir_row_t d;
    d = rd_row(MODE_CONV, 6'd0, 6'd0, 3'd0, 3'd0);
    d.reg_wr = 1'b1;
    d.idx = idx;
    d.data = data;
    return d;
  endfunction

  task automatic send_word(input word_t w, input int gap, input bit typed,
                           input weight_rec_t typed_res);
    repeat (gap) @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start       <= 1'b1;
    mode        <= w.md;
    out_index   <= w.o;
    in_index    <= w.i;
    kern_row    <= w.r;
    kern_col    <= w.c;
    entry_addr  <= w.addr;
    entry_value <= w.val;
    do @(posedge clk); while (busy);
    if (w.md == MODE_WR) book_mem[w.addr] = w.val;
    else weight_q.push_back(typed ? typed_res : hash_lookup(w));
  endtask

  task automatic drain_results();
    @(negedge clk) start <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk);
    // write words give no result and may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    drain_results();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk) cfg_write <= 1'b0;
    case (idx)
      REG_LAYER:     layer_cfg = data[7:0];
      REG_BOOK_SIZE: bsize_cfg = data;
      REG_SIGN_EN:   sign_cfg = data[0];
      default:       ;
    endcase
  endtask

  always @(posedge clk) begin
    weight_rec_t exp_r;
    if (!rst && done) begin
      if (weight_q.size() == 0) begin
        $error("weight: no word expected, got %0d (bucket %0d)", weight, bucket);
        err_cnt++;
      end else begin
        exp_r = weight_q.pop_front();
        if (weight !== exp_r.wt) begin
          $error("weight: expected %0d, got %0d", exp_r.wt, weight);
          err_cnt++;
        end
        if (bucket !== exp_r.bk) begin
          $error("bucket: expected %0d, got %0d", exp_r.bk, bucket);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    weight_rec_t none;
    bit          burst;
    none.wt = '0;
    none.bk = '0;
    burst = 1'b0;

    // reset values: layer 0, book size 1, no sign flip
    dir_tab.push_back(wr_row(8'd0, 8'sh80));
    dir_tab.push_back(rd_chk(MODE_CONV, 6'd63, 6'd63, 3'd7, 3'd7, -9'sd128, 8'd0));
    dir_tab.push_back(rd_chk(MODE_DW,   6'd63, 6'd63, 3'd7, 3'd7, -9'sd128, 8'd0));
    dir_tab.push_back(rd_chk(MODE_LIN,  6'd63, 6'd63, 3'd7, 3'd7, -9'sd128, 8'd0));
    // negated minimum: saturates in conv/dw, not in linear
    dir_tab.push_back(cfg_row(REG_SIGN_EN, 9'd1));
    dir_tab.push_back(rd_chk(MODE_CONV, 6'd0, 6'd0, 3'd0, 3'd0, 9'sd127, 8'd0));
    dir_tab.push_back(rd_chk(MODE_DW,   6'd0, 6'd0, 3'd0, 3'd0, 9'sd127, 8'd0));
    dir_tab.push_back(rd_chk(MODE_LIN,  6'd0, 6'd0, 3'd0, 3'd0, 9'sd128, 8'd0));
    dir_tab.push_back(rd_chk(MODE_CONV, 6'd1, 6'd0, 3'd0, 3'd0, -9'sd128, 8'd0));
    dir_tab.push_back(wr_row(8'd0, 8'sd127));
    dir_tab.push_back(rd_chk(MODE_LIN,  6'd0, 6'd0, 3'd0, 3'd0, -9'sd127, 8'd0));
    // book size 0 behaves as 1
    dir_tab.push_back(cfg_row(REG_BOOK_SIZE, 9'd0));
    dir_tab.push_back(rd_chk(MODE_DW,   6'd5, 6'd0, 3'd0, 3'd0, 9'sd127, 8'd0));
    // unused register index leaves everything alone
    dir_tab.push_back(cfg_row(REG_UNUSED, 9'h1FF));
    dir_tab.push_back(rd_chk(MODE_CONV, 6'd0, 6'd0, 3'd0, 3'd0, -9'sd127, 8'd0));
    dir_tab.push_back(wr_row(8'd1, -8'sd1));
    dir_tab.push_back(wr_row(8'd255, 8'sd127));
    dir_tab.push_back(cfg_row(REG_BOOK_SIZE, 9'd2));
    dir_tab.push_back(cfg_row(REG_LAYER, 9'd255));
    dir_tab.push_back(rd_row(MODE_CONV, 6'd63, 6'd63, 3'd7, 3'd7));
    dir_tab.push_back(rd_row(MODE_DW,   6'd63, 6'd0, 3'd7, 3'd7));
    dir_tab.push_back(rd_row(MODE_LIN,  6'd63, 6'd63, 3'd0, 3'd0));
    dir_tab.push_back(rd_row(MODE_LIN,  6'd0, 6'd0, 3'd0, 3'd0));
    dir_tab.push_back(cfg_row(REG_SIGN_EN, 9'd0));
    dir_tab.push_back(rd_row(MODE_CONV, 6'd1, 6'd2, 3'd3, 3'd4));

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].reg_wr) write_reg(dir_tab[k].idx, dir_tab[k].data);
      else send_word(dir_tab[k].w, $urandom_range(0, 11), dir_tab[k].typed, dir_tab[k].res);
    end

    // fill the whole codebook so any bucket may be read afterwards
    for (int a = 0; a < 256; a++)
      send_word(mk_word(MODE_WR, 6'($urandom), 6'($urandom), 3'($urandom), 3'($urandom),
                        8'(a), 8'($urandom)),
                $urandom_range(0, 11), 1'b0, none);

    ph_layer[6] = $urandom_range(0, 255);
    ph_size[6]  = $urandom_range(1, 256);
    ph_sign[6]  = $urandom_range(0, 1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_LAYER, 9'(ph_layer[p]));
      write_reg(REG_BOOK_SIZE, 9'(ph_size[p]));
      write_reg(REG_SIGN_EN, 9'(ph_sign[p]));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        if (p % 2 == 0 && n == PHASE_WORDS / 2) drain_results();
        send_word(rand_word(), burst ? 0 : $urandom_range(0, 11), 1'b0, none);
      end
    end

    drain_results();
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
